@@ src/tdq_pkg.sv @@
`default_nettype none

package tdq_pkg;

  localparam logic [2:0] MODE_UINT8_ASYM = 3'd0;
  localparam logic [2:0] MODE_INT8_FIXED = 3'd1;
  localparam logic [2:0] MODE_INT16_FIXED = 3'd2;
  localparam logic [2:0] MODE_FP16 = 3'd3;
  localparam logic [2:0] MODE_FP32 = 3'd4;

  localparam logic [1:0] REG_FORMAT_MODE = 2'd0;
  localparam logic [1:0] REG_SCALE_BITS = 2'd1;
  localparam logic [1:0] REG_ZERO_OFFSET = 2'd2;
  localparam logic [1:0] REG_FRAC_LENGTH = 2'd3;

  localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;
  localparam logic [31:0] FP32_INF = 32'h7F80_0000;
  localparam logic [31:0] FP32_DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [31:0] FP32_QUIET_BIT = 32'h0040_0000;
  localparam logic [31:0] HALF_REBIAS = 32'h3800_0000;

  typedef struct packed {
    logic [2:0]  format_mode;
    logic [31:0] scale_bits;
    logic [8:0]  zero_offset;
    logic [5:0]  frac_length;
  } cfg_t;

  typedef struct packed {
    logic [32:0] prod;
    logic [7:0]  exp;
    logic        sign;
    logic        direct;
    logic [31:0] direct_bits;
    logic        err;
    logic        last;
  } front_t;

  typedef struct packed {
    logic [32:0] prod;
    logic [5:0]  shift;
    logic [8:0]  exp_base;
    logic        zero;
    logic        sign;
    logic        direct;
    logic [31:0] direct_bits;
    logic        err;
    logic        last;
  } norm_t;

  typedef struct packed {
    logic [31:0] result_bits;
    logic        err;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

@@ src/tdq_cfg.sv @@
`default_nettype none

module tdq_cfg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [31:0]    cfg_wdata,
  output tdq_pkg::cfg_t       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.format_mode <= tdq_pkg::MODE_UINT8_ASYM;
      cfg.scale_bits  <= tdq_pkg::SCALE_RESET;
      cfg.zero_offset <= '0;
      cfg.frac_length <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tdq_pkg::REG_FORMAT_MODE: cfg.format_mode <= cfg_wdata[2:0];
        tdq_pkg::REG_SCALE_BITS:  cfg.scale_bits  <= cfg_wdata;
        tdq_pkg::REG_ZERO_OFFSET: cfg.zero_offset <= cfg_wdata[8:0];
        tdq_pkg::REG_FRAC_LENGTH: cfg.frac_length <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/tdq_front.sv @@
`default_nettype none

module tdq_front (
  input  wire tdq_pkg::cfg_t  cfg,
  input  wire logic [31:0]    raw,
  input  wire logic           last,
  output tdq_pkg::front_t     front
);

  logic signed [9:0] diff;
  logic [9:0]  diff_mag;
  logic [8:0]  u_mag;
  logic        u_sign;
  logic        s_sign;
  logic [7:0]  s_exp;
  logic [22:0] s_frac;
  logic [23:0] s_mant;
  logic [15:0] fix_val;
  logic [15:0] fix_mag;
  logic [7:0]  fix_exp;
  logic [32:0] u_prod;
  logic [31:0] half_body;

  always_comb begin
    diff     = $signed({2'b00, raw[7:0]}) - $signed({cfg.zero_offset[8], cfg.zero_offset});
    u_sign   = diff[9];
    diff_mag = u_sign ? 10'(-diff) : 10'(diff);
    u_mag    = diff_mag[8:0];
    s_sign   = cfg.scale_bits[31];
    s_exp    = cfg.scale_bits[30:23];
    s_frac   = cfg.scale_bits[22:0];
    s_mant   = {(s_exp != 8'd0), s_frac};
    u_prod   = 33'(u_mag) * 33'(s_mant);

    fix_val = (cfg.format_mode == tdq_pkg::MODE_INT8_FIXED) ?
              {{8{raw[7]}}, raw[7:0]} : raw[15:0];
    fix_mag = fix_val[15] ? 16'(~fix_val + 16'd1) : fix_val;
    fix_exp = 8'd150 - {{2{cfg.frac_length[5]}}, cfg.frac_length};

    half_body = (32'(raw[14:0]) << 13) + tdq_pkg::HALF_REBIAS;
    if (raw[14:10] == 5'd0) begin
      half_body = '0;
    end

    front.prod        = '0;
    front.exp         = 8'd1;
    front.sign        = 1'b0;
    front.direct      = 1'b1;
    front.direct_bits = '0;
    front.err         = 1'b0;
    front.last        = last;

    unique case (cfg.format_mode)
      tdq_pkg::MODE_UINT8_ASYM: begin
        front.sign = u_sign ^ s_sign;
        if (s_exp == 8'hFF) begin
          if (s_frac != 23'd0) begin
            front.direct_bits = cfg.scale_bits | tdq_pkg::FP32_QUIET_BIT;
          end else if (u_mag == 9'd0) begin
            front.direct_bits = tdq_pkg::FP32_DEFAULT_NAN;
          end else begin
            front.direct_bits = {u_sign ^ s_sign, tdq_pkg::FP32_INF[30:0]};
          end
        end else begin
          front.direct = 1'b0;
          front.prod   = u_prod;
          front.exp    = (s_exp == 8'd0) ? 8'd1 : s_exp;
        end
      end
      tdq_pkg::MODE_INT8_FIXED, tdq_pkg::MODE_INT16_FIXED: begin
        front.direct = 1'b0;
        front.sign   = fix_val[15];
        front.prod   = 33'(fix_mag);
        front.exp    = fix_exp;
      end
      tdq_pkg::MODE_FP16: begin
        front.direct_bits = half_body | {raw[15], 31'd0};
      end
      tdq_pkg::MODE_FP32: begin
        front.direct_bits = raw;
      end
      default: begin
        front.err = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/tdq_norm.sv @@
`default_nettype none

module tdq_norm (
  input  wire tdq_pkg::front_t front,
  output tdq_pkg::norm_t       norm
);

  logic [5:0]        lead;
  logic signed [9:0] k_norm;
  logic signed [9:0] k_sub;
  logic signed [9:0] k_sel;
  logic signed [9:0] exp_sum;

  always_comb begin
    lead = '0;
    for (int i = 0; i < 33; i++) begin
      if (front.prod[i]) begin
        lead = 6'(i);
      end
    end
    k_norm  = $signed({4'b0000, lead});
    k_sub   = 10'sd24 - $signed({2'b00, front.exp});
    k_sel   = (k_norm > k_sub) ? k_norm : k_sub;
    exp_sum = k_sel + $signed({2'b00, front.exp}) - 10'sd24;

    norm.prod        = front.prod;
    norm.shift       = k_sel[5:0];
    norm.exp_base    = exp_sum[8:0];
    norm.zero        = (front.prod == 33'd0);
    norm.sign        = front.sign;
    norm.direct      = front.direct;
    norm.direct_bits = front.direct_bits;
    norm.err         = front.err;
    norm.last        = front.last;
  end

endmodule

`default_nettype wire

@@ src/tdq_round.sv @@
`default_nettype none

module tdq_round (
  input  wire tdq_pkg::norm_t norm,
  output tdq_pkg::res_t       res
);

  logic [46:0] shifted;
  logic [23:0] mant;
  logic        guard;
  logic        sticky;
  logic        inc;
  logic [32:0] packed_sum;
  logic [30:0] mag;

  always_comb begin
    shifted    = 47'({norm.prod, 46'd0} >> norm.shift);
    mant       = shifted[46:23];
    guard      = shifted[22];
    sticky     = |shifted[21:0];
    inc        = guard & (sticky | mant[0]);
    packed_sum = {1'b0, norm.exp_base, 23'd0} + 33'(mant) + 33'(inc);
    if (packed_sum >= 33'(tdq_pkg::FP32_INF)) begin
      mag = tdq_pkg::FP32_INF[30:0];
    end else begin
      mag = packed_sum[30:0];
    end
    if (norm.direct) begin
      res.result_bits = norm.direct_bits;
    end else if (norm.zero) begin
      res.result_bits = {norm.sign, 31'd0};
    end else begin
      res.result_bits = {norm.sign, mag};
    end
    res.err  = norm.err;
    res.last = norm.last;
  end

endmodule

`default_nettype wire

@@ src/tensor_dequantize_to_fp32_unit.sv @@
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    raw_value, last_element
// out       output     out_valid / out_ready  result_bits, format_error, last_result
// cfg       input      cfg_we                 cfg_index, cfg_wdata
//
// Each request passes through four register stages: input, product, normalize, result.
// One request is accepted every cycle unless a stalled output has filled every stage.
// The 9x24 product, the leading-one search and the round-and-pack adder each own a stage.
// Reset is synchronous and clears all stage valid flags and the configuration registers.
// A stalled output holds its stage; earlier stages keep filling until all are occupied.
`default_nettype none

module tensor_dequantize_to_fp32_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] raw_value,
  input  wire logic        last_element,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      result_bits,
  output logic             format_error,
  output logic             last_result
);

  tdq_pkg::cfg_t   cfg;
  tdq_pkg::front_t front_c;
  tdq_pkg::front_t front_q;
  tdq_pkg::norm_t  norm_c;
  tdq_pkg::norm_t  norm_q;
  tdq_pkg::res_t   res_c;
  tdq_pkg::res_t   res_q;

  logic [31:0] raw_q;
  logic        last_q;
  logic        v1, v2, v3, v4;
  logic        load1, load2, load3, load4;

  tdq_cfg u_cfg (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .cfg(cfg)
  );

  tdq_front u_front (.cfg(cfg), .raw(raw_q), .last(last_q), .front(front_c));
  tdq_norm  u_norm  (.front(front_q), .norm(norm_c));
  tdq_round u_round (.norm(norm_q), .res(res_c));

  assign load4    = !v4 || out_ready;
  assign load3    = !v3 || load4;
  assign load2    = !v2 || load3;
  assign load1    = !v1 || load2;
  assign in_ready = load1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (load1) v1 <= in_valid;
      if (load2) v2 <= v1;
      if (load3) v3 <= v2;
      if (load4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (load1 && in_valid) begin
      raw_q  <= raw_value;
      last_q <= last_element;
    end
    if (load2 && v1) front_q <= front_c;
    if (load3 && v2) norm_q  <= norm_c;
    if (load4 && v3) res_q   <= res_c;
  end

  assign out_valid    = v4;
  assign result_bits  = res_q.result_bits;
  assign format_error = res_q.err;
  assign last_result  = res_q.last;

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && format_error |-> result_bits == 32'd0)
    else $error("format error with nonzero result");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    v4 && !out_ready |=> v4 && $stable(res_q))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !v1 && !v2 && !v3)
    else $error("pipeline not empty after reset");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    v1 && v2 && v3 && v4 && !out_ready |-> !in_ready)
    else $error("accepted request into a full pipeline");

  a_err_mode: assert property (@(posedge clk) disable iff (rst)
    v1 && load2 && front_c.err |-> cfg.format_mode != tdq_pkg::MODE_UINT8_ASYM
      && cfg.format_mode != tdq_pkg::MODE_INT8_FIXED
      && cfg.format_mode != tdq_pkg::MODE_INT16_FIXED
      && cfg.format_mode != tdq_pkg::MODE_FP16
      && cfg.format_mode != tdq_pkg::MODE_FP32)
    else $error("format error on a supported mode");

endmodule

`default_nettype wire
